// ===== sv/bbc_pkg.sv =====
`timescale 1ns / 1ps

package bbc_pkg;

    // Largest volume extent along any axis.
    localparam int MAX_DIM = 1024;
    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int SIZE_W  = POS_W + 1;

    localparam int VOXEL_W = 16;
    localparam int MARGIN_W = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_Z  = 3'd6;

    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [SIZE_W-1:0]   size_t;
    typedef logic [MARGIN_W-1:0] margin_t;

    // Result of one axis: low corner, kept extent and doubled centre.
    typedef struct packed {
        pos_t  lo;
        size_t crop;
        size_t centre2;
    } axis_res_t;

    // Step controls from the top level to each axis.
    typedef struct packed {
        logic take;    // a voxel item is accepted
        logic adv;     // this axis counter moves on
        logic hit;     // accepted voxel is foreground
        logic first;   // first foreground voxel of the volume
        logic found;   // finished volume held foreground
    } axis_ctl_t;

    // Size zero counts as one, anything above the maximum as the maximum.
    function automatic size_t eff_size(input size_t s);
        size_t r;
        if (s == '0) begin
            r = size_t'(1);
        end else if (s > size_t'(MAX_DIM)) begin
            r = size_t'(MAX_DIM);
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

// ===== sv/bbc_axis.sv =====
`timescale 1ns / 1ps

module bbc_axis (
    input  logic                aclk,
    input  logic                aresetn,
    input  bbc_pkg::axis_ctl_t  ctl,
    input  bbc_pkg::size_t      size_eff,
    input  bbc_pkg::margin_t    margin,
    output logic                wrap,
    output bbc_pkg::axis_res_t  res
);
    import bbc_pkg::*;

    pos_t  scan_reg, scan_next;
    pos_t  min_reg, min_next;
    pos_t  max_reg, max_next;
    size_t last;
    pos_t  pos;
    size_t pos_inc;

    logic signed [SIZE_W:0] lo_diff;
    size_t lo_clip;
    size_t hi_sum;
    size_t hi_clip;
    size_t lo_fin;
    size_t hi_fin;

    // A counter left beyond the last index by a size change reads as the last index.
    assign last    = size_eff - size_t'(1);
    assign pos     = ({1'b0, scan_reg} > last) ? last[POS_W-1:0] : scan_reg;
    assign pos_inc = {1'b0, pos} + size_t'(1);
    assign wrap    = (pos_inc >= size_eff);

    // Counter and running extrema update. An accepted voxel also stores the
    // clamped position, so a later size change starts from it.
    always_comb begin
        scan_next = scan_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        if (ctl.take) begin
            scan_next = pos;
        end
        if (ctl.adv) begin
            scan_next = wrap ? '0 : pos_inc[POS_W-1:0];
        end
        if (ctl.hit) begin
            if (ctl.first) begin
                min_next = pos;
                max_next = pos;
            end else begin
                if (pos < min_reg) min_next = pos;
                if (pos > max_reg) max_next = pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= '0;
            min_reg  <= '1;
            max_reg  <= '0;
        end else begin
            scan_reg <= scan_next;
            min_reg  <= min_next;
            max_reg  <= max_next;
        end
    end

    // Widen by the margin, clamp to the volume and keep low at or below high; with no foreground, the whole axis.
    always_comb begin
        lo_diff = $signed({2'b00, min_reg}) - $signed({2'b00, margin});
        lo_clip = lo_diff[SIZE_W] ? '0 : lo_diff[SIZE_W-1:0];
        hi_sum  = {1'b0, max_reg} + {1'b0, margin};
        hi_clip = (hi_sum > last) ? last : hi_sum;
        if (ctl.found) begin
            hi_fin = hi_clip;
            lo_fin = (lo_clip > hi_clip) ? hi_clip : lo_clip;
        end else begin
            hi_fin = last;
            lo_fin = '0;
        end
        res.lo      = lo_fin[POS_W-1:0];
        res.crop    = hi_fin - lo_fin + size_t'(1);
        res.centre2 = hi_fin + lo_fin;
    end

endmodule

// ===== sv/foreground_bounding_box_crop_core.sv =====
`timescale 1ns / 1ps

// Channel  Ports                         Direction  Moves
// s_       s_valid/s_ready/s_voxel_value in         one voxel item, raster order x fastest
// m_       m_valid/m_ready/m_*           out        one box item per finished volume
// cfg_     cfg_valid/cfg_ready/index/data in        one register write, always ready
//
// One voxel item is accepted every cycle unless a pending box stalls the input;
// the extrema compare and counter step sit between the input port and the state
// registers. The last voxel of a volume marks the box pending; once the output
// register is free, the margin and clamp logic fills it and m_valid rises.
// Input stalls only while a box is pending and the output register is still held.
// Synchronous active-low reset restores the default registers and an empty scan.

module foreground_bounding_box_crop_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [bbc_pkg::VOXEL_W-1:0] s_voxel_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_found,
    output logic [9:0]                        m_low_x,
    output logic [9:0]                        m_low_y,
    output logic [9:0]                        m_low_z,
    output logic [10:0]                       m_crop_x,
    output logic [10:0]                       m_crop_y,
    output logic [10:0]                       m_crop_z,
    output logic [10:0]                       m_centre2_x,
    output logic [10:0]                       m_centre2_y,
    output logic [10:0]                       m_centre2_z,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bbc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bbc_pkg::*;

    size_t   size_x_reg, size_y_reg, size_z_reg;
    logic signed [VOXEL_W-1:0] threshold_reg;
    margin_t margin_x_reg, margin_y_reg, margin_z_reg;

    logic any_fg_reg, any_fg_next;
    logic fin_reg, fin_next;
    logic m_valid_reg, m_valid_next;
    axis_res_t res_x_reg, res_y_reg, res_z_reg;
    logic found_reg;

    logic accept, hit, first, out_free, load, last_voxel;
    logic wrap_x, wrap_y, wrap_z;
    axis_ctl_t ctl_x, ctl_y, ctl_z;
    axis_res_t res_x, res_y, res_z;

    // Configuration registers; writes beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg    <= size_t'(MAX_DIM);
            size_y_reg    <= size_t'(MAX_DIM);
            size_z_reg    <= size_t'(1);
            threshold_reg <= '0;
            margin_x_reg  <= '0;
            margin_y_reg  <= '0;
            margin_z_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SIZE_X:    size_x_reg    <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:    size_y_reg    <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Z:    size_z_reg    <= cfg_data[SIZE_W-1:0];
                REG_THRESHOLD: threshold_reg <= $signed(cfg_data[VOXEL_W-1:0]);
                REG_MARGIN_X:  margin_x_reg  <= cfg_data[MARGIN_W-1:0];
                REG_MARGIN_Y:  margin_y_reg  <= cfg_data[MARGIN_W-1:0];
                REG_MARGIN_Z:  margin_z_reg  <= cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake and step control. A pending box means the extrema belong to the
    // finished volume, so the next voxel starts a fresh one.
    assign out_free   = !m_valid_reg || m_ready;
    assign load       = fin_reg && out_free;
    assign s_ready    = !fin_reg || out_free;
    assign accept     = s_valid && s_ready;
    assign hit        = accept && (s_voxel_value > threshold_reg);
    assign first      = !any_fg_reg || fin_reg;
    assign last_voxel = accept && wrap_x && wrap_y && wrap_z;

    always_comb begin
        ctl_x = '{take: accept, adv: accept, hit: hit, first: first, found: any_fg_reg};
        ctl_y = '{take: accept, adv: accept && wrap_x, hit: hit, first: first,
                  found: any_fg_reg};
        ctl_z = '{take: accept, adv: accept && wrap_x && wrap_y, hit: hit, first: first,
                  found: any_fg_reg};
    end

    bbc_axis u_axis_x (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl_x),
        .size_eff(eff_size(size_x_reg)), .margin(margin_x_reg),
        .wrap(wrap_x), .res(res_x)
    );

    bbc_axis u_axis_y (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl_y),
        .size_eff(eff_size(size_y_reg)), .margin(margin_y_reg),
        .wrap(wrap_y), .res(res_y)
    );

    bbc_axis u_axis_z (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl_z),
        .size_eff(eff_size(size_z_reg)), .margin(margin_z_reg),
        .wrap(wrap_z), .res(res_z)
    );

    // Foreground flag, pending-box flag and output valid.
    always_comb begin
        any_fg_next = any_fg_reg;
        if (accept) begin
            any_fg_next = (any_fg_reg && !fin_reg) || hit;
        end else if (load) begin
            any_fg_next = 1'b0;
        end
        fin_next = last_voxel ? 1'b1 : (load ? 1'b0 : fin_reg);
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_fg_reg  <= 1'b0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            any_fg_reg  <= any_fg_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output register for the box.
    always_ff @(posedge aclk) begin
        if (load) begin
            found_reg <= any_fg_reg;
            res_x_reg <= res_x;
            res_y_reg <= res_y;
            res_z_reg <= res_z;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_found     = found_reg;
    assign m_low_x     = res_x_reg.lo;
    assign m_low_y     = res_y_reg.lo;
    assign m_low_z     = res_z_reg.lo;
    assign m_crop_x    = res_x_reg.crop;
    assign m_crop_y    = res_y_reg.crop;
    assign m_crop_z    = res_z_reg.crop;
    assign m_centre2_x = res_x_reg.centre2;
    assign m_centre2_y = res_y_reg.centre2;
    assign m_centre2_z = res_z_reg.centre2;

    // The last voxel of a volume always leaves a box pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        last_voxel |=> fin_reg)
        else $error("last voxel did not mark a box pending");

    // A pending box that cannot move out blocks further voxels.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("voxel accepted while a box was blocked");

    // A box leaves the pending flag and enters the output register together.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !last_voxel) |=> (m_valid_reg && !fin_reg))
        else $error("pending box not moved to output");

    // An empty volume reports the whole volume from the origin.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !found_reg) |-> (m_low_x == '0 && m_low_y == '0 && m_low_z == '0))
        else $error("empty volume reported a nonzero low corner");

    // A reported box never has zero extent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_crop_x != '0 && m_crop_y != '0 && m_crop_z != '0))
        else $error("box with zero extent");

endmodule

// ===== sim/box_checker.sv =====
`timescale 1ns / 1ps

module box_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic signed [bbc_pkg::VOXEL_W-1:0] s_voxel_value,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic                               m_found,
    input  logic [9:0]                         m_low_x,
    input  logic [9:0]                         m_low_y,
    input  logic [9:0]                         m_low_z,
    input  logic [10:0]                        m_crop_x,
    input  logic [10:0]                        m_crop_y,
    input  logic [10:0]                        m_crop_z,
    input  logic [10:0]                        m_centre2_x,
    input  logic [10:0]                        m_centre2_y,
    input  logic [10:0]                        m_centre2_z,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bbc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                 mismatches,
    output int                                 boxes_due
);

    import bbc_pkg::*;

    // One predicted box item; axis 0 is x, 1 is y, 2 is z.
    typedef struct packed {
        logic            found;
        axis_res_t [2:0] per_axis;
    } box_t;

    // Shadow of the settings and of the scan state.
    size_t                     extent_reg [3];
    logic signed [VOXEL_W-1:0] threshold_reg;
    margin_t                   margin_reg [3];
    pos_t                      scan_pos [3];
    pos_t                      fg_lo [3];
    pos_t                      fg_hi [3];
    logic                      fg_seen;
    box_t                      box_q [$];

    // A zero extent counts as one voxel, anything above the maximum as the maximum.
    function automatic int usable_extent(input size_t s);
        int n;
        n = int'(s);
        if (n == 0) begin
            n = 1;
        end else if (n > MAX_DIM) begin
            n = MAX_DIM;
        end
        return n;
    endfunction

    // Widen one axis range by its margin and clamp it to the volume; with no foreground, the whole axis.
    function automatic axis_res_t crop_axis(input logic fg, input pos_t lo, input pos_t hi,
                                            input margin_t margin, input int extent);
        int        a;
        int        b;
        axis_res_t r;
        if (fg) begin
            a = int'(lo) - int'(margin);
            b = int'(hi) + int'(margin);
            if (a < 0) a = 0;
            if (b > extent - 1) b = extent - 1;
            if (a > b) a = b;
        end else begin
            a = 0;
            b = extent - 1;
        end
        r.lo      = pos_t'(a);
        r.crop    = size_t'(b - a + 1);
        r.centre2 = size_t'(a + b);
        return r;
    endfunction

    task automatic clear_scan();
        for (int i = 0; i < 3; i++) begin
            scan_pos[i] = '0;
            fg_lo[i]    = '1;
            fg_hi[i]    = '0;
        end
        fg_seen = 1'b0;
    endtask

    // Track one accepted voxel item and queue a box when the volume ends.
    task automatic take_voxel(input logic signed [VOXEL_W-1:0] v);
        int   ext [3];
        logic carry;
        box_t box;
        for (int i = 0; i < 3; i++) begin
            ext[i] = usable_extent(extent_reg[i]);
            if (int'(scan_pos[i]) >= ext[i]) scan_pos[i] = pos_t'(ext[i] - 1);
        end

        if (v > threshold_reg) begin
            for (int i = 0; i < 3; i++) begin
                if (!fg_seen || scan_pos[i] < fg_lo[i]) fg_lo[i] = scan_pos[i];
                if (!fg_seen || scan_pos[i] > fg_hi[i]) fg_hi[i] = scan_pos[i];
            end
            fg_seen = 1'b1;
        end

        // Step the counters, x fastest; a carry out of z ends the volume.
        carry = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (carry) begin
                if (int'(scan_pos[i]) + 1 >= ext[i]) begin
                    scan_pos[i] = '0;
                end else begin
                    scan_pos[i] = scan_pos[i] + 1'b1;
                    carry = 1'b0;
                end
            end
        end

        if (carry) begin
            box.found = fg_seen;
            for (int i = 0; i < 3; i++) begin
                box.per_axis[i] = crop_axis(fg_seen, fg_lo[i], fg_hi[i], margin_reg[i], ext[i]);
            end
            box_q.push_back(box);
            clear_scan();
        end
    endtask

    task automatic store_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SIZE_X:    extent_reg[0] = data[SIZE_W-1:0];
            REG_SIZE_Y:    extent_reg[1] = data[SIZE_W-1:0];
            REG_SIZE_Z:    extent_reg[2] = data[SIZE_W-1:0];
            REG_THRESHOLD: threshold_reg = data[VOXEL_W-1:0];
            REG_MARGIN_X:  margin_reg[0] = data[MARGIN_W-1:0];
            REG_MARGIN_Y:  margin_reg[1] = data[MARGIN_W-1:0];
            REG_MARGIN_Z:  margin_reg[2] = data[MARGIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge aclk) begin : watch
        box_t want;
        if (!aresetn) begin
            extent_reg[0] = size_t'(1024);
            extent_reg[1] = size_t'(1024);
            extent_reg[2] = size_t'(1);
            threshold_reg = '0;
            for (int i = 0; i < 3; i++) margin_reg[i] = '0;
            clear_scan();
            box_q.delete();
            mismatches = 0;
        end else begin
            if (s_valid && s_ready) take_voxel(s_voxel_value);

            if (m_valid && m_ready) begin
                if (box_q.size() == 0) begin
                    $display("%0t: box item expected none, got found=%0d low=%0d/%0d/%0d",
                             $time, m_found, m_low_x, m_low_y, m_low_z);
                    mismatches++;
                end else begin
                    want = box_q.pop_front();
                    check_field("found", want.found, m_found);
                    check_field("low_x", want.per_axis[0].lo, m_low_x);
                    check_field("low_y", want.per_axis[1].lo, m_low_y);
                    check_field("low_z", want.per_axis[2].lo, m_low_z);
                    check_field("crop_x", want.per_axis[0].crop, m_crop_x);
                    check_field("crop_y", want.per_axis[1].crop, m_crop_y);
                    check_field("crop_z", want.per_axis[2].crop, m_crop_z);
                    check_field("centre2_x", want.per_axis[0].centre2, m_centre2_x);
                    check_field("centre2_y", want.per_axis[1].centre2, m_centre2_y);
                    check_field("centre2_z", want.per_axis[2].centre2, m_centre2_z);
                end
            end

            // Settings written at this edge apply from the next voxel on.
            if (cfg_valid && cfg_ready) store_setting(cfg_index, cfg_data);
        end
        boxes_due = box_q.size();
    end

endmodule

// ===== sim/tb_foreground_bounding_box_crop_core.sv =====
`timescale 1ns / 1ps

module tb_foreground_bounding_box_crop_core;

    import bbc_pkg::*;

    // Index with no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 600;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic signed [VOXEL_W-1:0] s_voxel_value = '0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic                      m_found;
    logic [9:0]                m_low_x, m_low_y, m_low_z;
    logic [10:0]               m_crop_x, m_crop_y, m_crop_z;
    logic [10:0]               m_centre2_x, m_centre2_y, m_centre2_z;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index     = '0;
    logic [CFG_DATA_W-1:0]     cfg_data      = '0;

    int mismatches;
    int boxes_due;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int thr_now        = 0;
    int volume_len     = 1;
    int items_sent     = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    foreground_bounding_box_crop_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_voxel_value (s_voxel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_low_x       (m_low_x),
        .m_low_y       (m_low_y),
        .m_low_z       (m_low_z),
        .m_crop_x      (m_crop_x),
        .m_crop_y      (m_crop_y),
        .m_crop_z      (m_crop_z),
        .m_centre2_x   (m_centre2_x),
        .m_centre2_y   (m_centre2_y),
        .m_centre2_z   (m_centre2_z),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    box_checker u_box_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_voxel_value (s_voxel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_low_x       (m_low_x),
        .m_low_y       (m_low_y),
        .m_low_z       (m_low_z),
        .m_crop_x      (m_crop_x),
        .m_crop_y      (m_crop_y),
        .m_crop_z      (m_crop_z),
        .m_centre2_x   (m_centre2_x),
        .m_centre2_y   (m_centre2_y),
        .m_centre2_z   (m_centre2_z),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .boxes_due     (boxes_due)
    );

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge aclk) begin
        m_ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Hang-up guard.
    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    // Random filler above the register width, which the block must drop.
    function automatic logic [CFG_DATA_W-1:0] with_spare_bits(input int value, input int width);
        logic [CFG_DATA_W-1:0] mask;
        mask = '1 << width;
        return (CFG_DATA_W'($urandom) & mask) | (CFG_DATA_W'(value) & ~mask);
    endfunction

    function automatic int extent_of(input int s);
        return (s == 0) ? 1 : ((s > MAX_DIM) ? MAX_DIM : s);
    endfunction

    // Voxel value above or at most at the current threshold, often right next to it; now and then a fully random value.
    function automatic logic signed [VOXEL_W-1:0] make_voxel(input logic fg);
        int room;
        int v;
        if ($urandom_range(7) == 0) begin
            v = int'($urandom);
        end else if (fg && thr_now < 32767) begin
            room = 32767 - thr_now;
            if ($urandom_range(1) == 1) v = thr_now + 1 + int'($urandom_range(room - 1));
            else v = thr_now + 1 + int'($urandom_range((room > 3) ? 2 : room - 1));
        end else begin
            room = thr_now + 32768;
            if ($urandom_range(1) == 1) v = thr_now - int'($urandom_range(room));
            else v = thr_now - int'($urandom_range((room > 2) ? 2 : room));
        end
        return VOXEL_W'(v);
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Stop sending and wait until every box has come out and the block is quiet.
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        wait (boxes_due == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setup(input int sx, input int sy, input int sz, input int thr,
                               input int mx, input int my, input int mz);
        drain();
        cfg_write(REG_SIZE_X, with_spare_bits(sx, SIZE_W));
        cfg_write(REG_SIZE_Y, with_spare_bits(sy, SIZE_W));
        cfg_write(REG_SIZE_Z, with_spare_bits(sz, SIZE_W));
        cfg_write(REG_THRESHOLD, CFG_DATA_W'(thr));
        cfg_write(REG_MARGIN_X, with_spare_bits(mx, MARGIN_W));
        cfg_write(REG_MARGIN_Y, with_spare_bits(my, MARGIN_W));
        cfg_write(REG_MARGIN_Z, with_spare_bits(mz, MARGIN_W));
        @(negedge aclk);
        cfg_valid  = 1'b0;
        thr_now    = thr;
        volume_len = extent_of(sx) * extent_of(sy) * extent_of(sz);
    endtask

    // Offer one voxel item, idling first at random, and hold it until taken.
    task automatic send_voxel(input logic signed [VOXEL_W-1:0] v);
        @(negedge aclk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_voxel_value = v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_volume(input int fg_pct);
        for (int n = 0; n < volume_len; n++) begin
            send_voxel(make_voxel($urandom_range(99) < fg_pct));
        end
    endtask

    initial begin
        int vol_a [8] = '{0, -32768, 0, 0, 0, 32767, 0, 1};
        int phase;
        int n_vol;
        int sz [3];
        int mg [3];
        int thr;
        int fg_pct;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: a 2x2x2 volume with foreground at the far x edge, margins from zero on x to wide on z.
        apply_setup(2, 2, 2, 0, 0, 1, 1023);
        foreach (vol_a[i]) send_voxel(vol_a[i]);
        // Same volume with nothing above the threshold.
        repeat (8) send_voxel(0);

        // Zero sizes act as one voxel; threshold at both ends of its range.
        apply_setup(0, 0, 0, 32767, 0, 0, 0);
        send_voxel(32767);
        send_voxel(-32768);
        apply_setup(0, 0, 0, -32768, 0, 0, 0);
        send_voxel(-32768);
        send_voxel(-32767);

        // Shrink x in the middle of a volume, past the recorded foreground.
        apply_setup(4, 1, 1, 0, 0, 0, 0);
        send_voxel(0);
        send_voxel(0);
        send_voxel(5);
        drain();
        cfg_write(REG_SIZE_X, CFG_DATA_W'(2));
        cfg_write(REG_SPARE, '1);
        @(negedge aclk);
        cfg_valid = 1'b0;
        send_voxel(0);

        // Random phases of small volumes, idling pattern changing per phase.
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS) begin
            for (int i = 0; i < 3; i++) begin
                sz[i] = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 4));
                case ($urandom_range(5))
                    0:       mg[i] = 0;
                    1:       mg[i] = 1023;
                    2:       mg[i] = int'($urandom_range(1023));
                    default: mg[i] = int'($urandom_range(2));
                endcase
            end
            case ($urandom_range(5))
                0:       thr = -32768;
                1:       thr = 32767;
                2, 3:    thr = int'($signed(16'($urandom)));
                default: thr = int'($urandom_range(16)) - 8;
            endcase
            apply_setup(sz[0], sz[1], sz[2], thr, mg[0], mg[1], mg[2]);

            case (phase % 5)
                1:       begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 53; end
                3:       begin send_idle_pct = 33; recv_stall_pct = 33; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase

            n_vol = $urandom_range(1, 4);
            repeat (n_vol) begin
                case ($urandom_range(3))
                    0:       fg_pct = 0;
                    1:       fg_pct = 5;
                    2:       fg_pct = 40;
                    default: fg_pct = 100;
                endcase
                send_volume(fg_pct);
            end

            // Sometimes leave a volume unfinished so the next settings land mid-scan.
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(volume_len - 1)) send_voxel(make_voxel($urandom_range(1)));
            end
            phase++;
        end

        // A long x scan with the extent written above the maximum, then cut short
        // by a smaller extent so the counter is pulled back and the volume ends.
        apply_setup(2047, 1, 1, 30000, 0, 1023, 5);
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        repeat (64) send_voxel(make_voxel($urandom_range(99) < 20));
        drain();
        cfg_write(REG_SIZE_X, CFG_DATA_W'(40));
        @(negedge aclk);
        cfg_valid = 1'b0;
        send_voxel(make_voxel(1'b1));

        drain();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== foreground_bounding_box_crop_core.f =====
sv/bbc_pkg.sv
sv/bbc_axis.sv
sv/foreground_bounding_box_crop_core.sv
sim/box_checker.sv
sim/tb_foreground_bounding_box_crop_core.sv
